// ===== src/rmq_pkg.sv =====
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared constants, types and helpers for the rotation matrix to quaternion
// pipeline.
// ---------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int NUM_W      = IN_W + 1;
  localparam int ROOT1_W    = 16;

  // square root unit: 62-bit radicand, one result bit per stage
  localparam int RAD_W      = 62;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 3;
  localparam int SQ_STAGES  = RAD_W / 2;

  // divider: one quotient bit per stage
  localparam int DVD_W      = 46;
  localparam int DSR_W      = 32;
  localparam int DIV_STAGES = DVD_W;

  localparam int MAG_W      = 30;
  localparam int SQR_W      = 2 * MAG_W;

  localparam int ONE_I      = 1 << FRAC_BITS;
  localparam int LIM_I      = (ONE_I > 32767) ? 32767 : ONE_I;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2,
    AX_W = 2'd3
  } axis_t;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    num_t [3:0] num;
    axis_t      carried;
  } front_side_t;

  typedef struct packed {
    logic [3:0]         neg;
    axis_t              carried;
    logic [ROOT1_W-1:0] root;
  } div1_side_t;

  typedef struct packed {
    logic [3:0]            neg;
    logic [3:0][MAG_W-1:0] mag;
    logic                  deg;
  } norm_side_t;

  typedef struct packed {
    logic [3:0] neg;
    logic       deg;
  } out_side_t;

  function automatic logic signed [OUT_W-1:0] sat_out(logic [DVD_W-1:0] q, logic neg);
    logic [OUT_W-1:0] mag;
    mag = (q > DVD_W'(LIM_I)) ? OUT_W'(LIM_I) : q[OUT_W-1:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== src/rmq_front.sv =====
// ---------------------------------------------------------------------------
// rmq_front
// Branch selection, square root radicand and numerators, two stages.
// ---------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [IN_W-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22,
  output logic                  out_valid,
  output logic [RAD_W-1:0]      rad,
  output front_side_t           side
);

  localparam int TR_W = IN_W + 2;
  localparam int A_W  = IN_W + 3;

  logic                   v1;
  logic signed [TR_W-1:0] tr;
  logic                   gt01, gt02, gt12;
  logic signed [IN_W-1:0] r00, r10, r20, r01, r11, r21, r02, r12, r22;

  logic signed [A_W-1:0]  a;
  logic [RAD_W-1:0]       rad_next;
  front_side_t            side_next;
  num_t d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tr   <= TR_W'(m00) + TR_W'(m11) + TR_W'(m22);
    gt01 <= m00 > m11;
    gt02 <= m00 > m22;
    gt12 <= m11 > m22;
    r00 <= m00; r10 <= m10; r20 <= m20;
    r01 <= m01; r11 <= m11; r21 <= m21;
    r02 <= m02; r12 <= m12; r22 <= m22;
  end

  always_comb begin
    d21_12 = NUM_W'(r21) - NUM_W'(r12);
    d02_20 = NUM_W'(r02) - NUM_W'(r20);
    d10_01 = NUM_W'(r10) - NUM_W'(r01);
    s01_10 = NUM_W'(r01) + NUM_W'(r10);
    s02_20 = NUM_W'(r02) + NUM_W'(r20);
    s12_21 = NUM_W'(r12) + NUM_W'(r21);
    if (!tr[TR_W-1] && tr != '0) begin
      a = A_W'(tr) + A_W'(ONE_I);
      side_next.carried = AX_W;
      side_next.num = {num_t'(0), d10_01, d02_20, d21_12};
    end else if (gt01 && gt02) begin
      a = A_W'(ONE_I) + A_W'(r00) - A_W'(r11) - A_W'(r22);
      side_next.carried = AX_X;
      side_next.num = {d21_12, s02_20, s01_10, num_t'(0)};
    end else if (gt12) begin
      a = A_W'(ONE_I) + A_W'(r11) - A_W'(r00) - A_W'(r22);
      side_next.carried = AX_Y;
      side_next.num = {d02_20, s12_21, num_t'(0), s01_10};
    end else begin
      a = A_W'(ONE_I) + A_W'(r22) - A_W'(r00) - A_W'(r11);
      side_next.carried = AX_Z;
      side_next.num = {d10_01, num_t'(0), s12_21, s02_20};
    end
    // non-positive radicand gives a zero root
    if (!a[A_W-1] && a != '0) begin
      rad_next = RAD_W'(a[A_W-2:0]) << FRAC_BITS;
    end else begin
      rad_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    rad  <= rad_next;
    side <= side_next;
  end

endmodule

// ===== src/rmq_sqrt.sv =====
// ---------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module rmq_sqrt import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root
);

  localparam int ACC_W = SQ_REM_W + 2;

  logic [SQ_STAGES-1:0] vld;
  logic [RAD_W-1:0]     rad_q   [SQ_STAGES];
  logic [SQ_REM_W-1:0]  rem_q   [SQ_STAGES];
  logic [ROOT_W-1:0]    root_q  [SQ_STAGES];
  logic [RAD_W-1:0]     rad_n   [SQ_STAGES];
  logic [SQ_REM_W-1:0]  rem_n   [SQ_STAGES];
  logic [ROOT_W-1:0]    root_n  [SQ_STAGES];

  always_comb begin
    for (int i = 0; i < SQ_STAGES; i++) begin
      logic [RAD_W-1:0]    rad_i;
      logic [SQ_REM_W-1:0] rem_i;
      logic [ROOT_W-1:0]   root_i;
      logic [ACC_W-1:0]    acc, trial;
      if (i == 0) begin
        rad_i  = rad;
        rem_i  = '0;
        root_i = '0;
      end else begin
        rad_i  = rad_q[i-1];
        rem_i  = rem_q[i-1];
        root_i = root_q[i-1];
      end
      acc   = {rem_i, rad_i[RAD_W-1 -: 2]};
      trial = ACC_W'({root_i, 2'b01});
      if (acc >= trial) begin
        rem_n[i]  = SQ_REM_W'(acc - trial);
        root_n[i] = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem_n[i]  = SQ_REM_W'(acc);
        root_n[i] = {root_i[ROOT_W-2:0], 1'b0};
      end
      rad_n[i] = rad_i << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[SQ_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQ_STAGES; i++) begin
      rad_q[i]  <= rad_n[i];
      rem_q[i]  <= rem_n[i];
      root_q[i] <= root_n[i];
    end
  end

  assign out_valid = vld[SQ_STAGES-1];
  assign root      = root_q[SQ_STAGES-1];

endmodule

// ===== src/rmq_div.sv =====
// ---------------------------------------------------------------------------
// rmq_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             out_valid,
  output logic [DVD_W-1:0] quotient
);

  localparam int ACC_W = DSR_W + 1;

  logic [DIV_STAGES-1:0] vld;
  logic [DVD_W-1:0] dvd_q [DIV_STAGES];
  logic [DSR_W-1:0] dsr_q [DIV_STAGES];
  logic [DSR_W-1:0] rem_q [DIV_STAGES];
  logic [DVD_W-1:0] quo_q [DIV_STAGES];
  logic [DVD_W-1:0] dvd_n [DIV_STAGES];
  logic [DSR_W-1:0] dsr_n [DIV_STAGES];
  logic [DSR_W-1:0] rem_n [DIV_STAGES];
  logic [DVD_W-1:0] quo_n [DIV_STAGES];

  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      logic [DVD_W-1:0] dvd_i, quo_i;
      logic [DSR_W-1:0] dsr_i, rem_i;
      logic [ACC_W-1:0] acc;
      if (i == 0) begin
        dvd_i = dividend;
        dsr_i = divisor;
        rem_i = '0;
        quo_i = '0;
      end else begin
        dvd_i = dvd_q[i-1];
        dsr_i = dsr_q[i-1];
        rem_i = rem_q[i-1];
        quo_i = quo_q[i-1];
      end
      acc = {rem_i, dvd_i[DVD_W-1]};
      if (acc >= ACC_W'(dsr_i)) begin
        rem_n[i] = DSR_W'(acc - ACC_W'(dsr_i));
        quo_n[i] = {quo_i[DVD_W-2:0], 1'b1};
      end else begin
        rem_n[i] = DSR_W'(acc);
        quo_n[i] = {quo_i[DVD_W-2:0], 1'b0};
      end
      dvd_n[i] = dvd_i << 1;
      dsr_n[i] = dsr_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      dvd_q[i] <= dvd_n[i];
      dsr_q[i] <= dsr_n[i];
      rem_q[i] <= rem_n[i];
      quo_q[i] <= quo_n[i];
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quotient  = quo_q[DIV_STAGES-1];

endmodule

// ===== src/rotation_matrix_to_quaternion.sv =====
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Fully pipelined conversion of a Q2.14 rotation matrix to a unit quaternion.
// ---------------------------------------------------------------------------
// Takes one request per clock: busy is always low, so start may be held high
// every cycle. Each request returns one result, marked by a one-cycle done
// strobe; the receiver cannot stall the block.
// The pipeline is made of the two pipelined square roots (31 stages each) and
// the two divider banks (46 stages each), plus 2 front stages, 4 stages for
// component selection and the squared length, and the output register.
// degenerate flags a zero root or zero length, with all components zero.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22,
  output logic                   done,
  output logic signed [OUT_W-1:0] qx, qy, qz, qw,
  output logic                   degenerate
);

  // front
  logic        fr_vld;
  logic [RAD_W-1:0] fr_rad;
  front_side_t fr_side;

  // first root
  logic              sq1_vld;
  logic [ROOT_W-1:0] sq1_root;
  front_side_t       fside_d [SQ_STAGES];

  // component division
  logic [DVD_W-1:0] d1_dvd [4];
  logic [DSR_W-1:0] d1_dsr;
  logic [DVD_W-1:0] d1_quo [4];
  logic [3:0]       d1_vld_v;
  div1_side_t       d1_side;
  div1_side_t       d1side_d [DIV_STAGES];

  // squared length
  logic                  c_vld, sqr_vld, pair_vld, sum_vld;
  logic [3:0][MAG_W-1:0] c_mag, sqr_mag, pair_mag, sum_mag;
  logic [3:0]            c_neg, sqr_neg, pair_neg, sum_neg;
  logic                  c_deg, sqr_deg, pair_deg, sum_deg;
  logic [SQR_W-1:0]      sqr [4];
  logic [SQR_W:0]        pair [2];
  logic [RAD_W-1:0]      sum;

  // length and normalization
  logic              sq2_vld;
  logic [ROOT_W-1:0] sq2_len;
  norm_side_t        nside_in;
  norm_side_t        nside_d [SQ_STAGES];
  logic [DVD_W-1:0]  d2_dvd [4];
  logic [DVD_W-1:0]  d2_quo [4];
  logic [3:0]        d2_vld_v;
  out_side_t         oside_in;
  out_side_t         oside_d [DIV_STAGES];

  assign busy = 1'b0;

  rmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .m00       (m00), .m10 (m10), .m20 (m20),
    .m01       (m01), .m11 (m11), .m21 (m21),
    .m02       (m02), .m12 (m12), .m22 (m22),
    .out_valid (fr_vld),
    .rad       (fr_rad),
    .side      (fr_side)
  );

  rmq_sqrt u_sqrt_s (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_vld),
    .rad       (fr_rad),
    .out_valid (sq1_vld),
    .root      (sq1_root)
  );

  always_ff @(posedge clk) begin
    fside_d[0] <= fr_side;
    for (int i = 1; i < SQ_STAGES; i++) begin
      fside_d[i] <= fside_d[i-1];
    end
  end

  // divisor is S = 2 * root; dividends are |num| scaled by one
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [NUM_W-1:0] mag;
      mag = fside_d[SQ_STAGES-1].num[i][NUM_W-1] ?
            NUM_W'(-$signed(fside_d[SQ_STAGES-1].num[i])) :
            NUM_W'(fside_d[SQ_STAGES-1].num[i]);
      d1_dvd[i] = DVD_W'(mag) << FRAC_BITS;
      d1_side.neg[i] = fside_d[SQ_STAGES-1].num[i][NUM_W-1];
    end
    d1_side.carried = fside_d[SQ_STAGES-1].carried;
    d1_side.root    = sq1_root[ROOT1_W-1:0];
    d1_dsr          = DSR_W'({sq1_root[ROOT1_W-1:0], 1'b0});
  end

  genvar g;
  for (g = 0; g < 4; g++) begin : g_div1
    rmq_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq1_vld),
      .dividend  (d1_dvd[g]),
      .divisor   (d1_dsr),
      .out_valid (d1_vld_v[g]),
      .quotient  (d1_quo[g])
    );
  end

  always_ff @(posedge clk) begin
    d1side_d[0] <= d1_side;
    for (int i = 1; i < DIV_STAGES; i++) begin
      d1side_d[i] <= d1side_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld    <= 1'b0;
      sqr_vld  <= 1'b0;
      pair_vld <= 1'b0;
      sum_vld  <= 1'b0;
    end else begin
      c_vld    <= &d1_vld_v;
      sqr_vld  <= c_vld;
      pair_vld <= sqr_vld;
      sum_vld  <= pair_vld;
    end
  end

  always_ff @(posedge clk) begin
    // carried component is S/4 = root/2
    for (int i = 0; i < 4; i++) begin
      if (d1side_d[DIV_STAGES-1].carried == axis_t'(2'(i))) begin
        c_mag[i] <= MAG_W'(d1side_d[DIV_STAGES-1].root >> 1);
        c_neg[i] <= 1'b0;
      end else begin
        c_mag[i] <= d1_quo[i][MAG_W-1:0];
        c_neg[i] <= d1side_d[DIV_STAGES-1].neg[i];
      end
    end
    c_deg <= d1side_d[DIV_STAGES-1].root == '0;

    for (int i = 0; i < 4; i++) begin
      sqr[i] <= SQR_W'(c_mag[i]) * SQR_W'(c_mag[i]);
    end
    sqr_mag <= c_mag;
    sqr_neg <= c_neg;
    sqr_deg <= c_deg;

    pair[0]  <= (SQR_W+1)'(sqr[0]) + (SQR_W+1)'(sqr[1]);
    pair[1]  <= (SQR_W+1)'(sqr[2]) + (SQR_W+1)'(sqr[3]);
    pair_mag <= sqr_mag;
    pair_neg <= sqr_neg;
    pair_deg <= sqr_deg;

    sum     <= RAD_W'(pair[0]) + RAD_W'(pair[1]);
    sum_mag <= pair_mag;
    sum_neg <= pair_neg;
    sum_deg <= pair_deg;
  end

  rmq_sqrt u_sqrt_len (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_vld),
    .rad       (sum),
    .out_valid (sq2_vld),
    .root      (sq2_len)
  );

  assign nside_in = '{neg: sum_neg, mag: sum_mag, deg: sum_deg};

  always_ff @(posedge clk) begin
    nside_d[0] <= nside_in;
    for (int i = 1; i < SQ_STAGES; i++) begin
      nside_d[i] <= nside_d[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d2_dvd[i] = DVD_W'(nside_d[SQ_STAGES-1].mag[i]) << FRAC_BITS;
    end
    oside_in.neg = nside_d[SQ_STAGES-1].neg;
    oside_in.deg = nside_d[SQ_STAGES-1].deg || (sq2_len == '0);
  end

  for (g = 0; g < 4; g++) begin : g_div2
    rmq_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq2_vld),
      .dividend  (d2_dvd[g]),
      .divisor   (DSR_W'(sq2_len)),
      .out_valid (d2_vld_v[g]),
      .quotient  (d2_quo[g])
    );
  end

  always_ff @(posedge clk) begin
    oside_d[0] <= oside_in;
    for (int i = 1; i < DIV_STAGES; i++) begin
      oside_d[i] <= oside_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= &d2_vld_v;
    end
  end

  // saturate, restore sign, zero on a degenerate request
  always_ff @(posedge clk) begin
    if (oside_d[DIV_STAGES-1].deg) begin
      qx <= '0;
      qy <= '0;
      qz <= '0;
      qw <= '0;
    end else begin
      qx <= sat_out(d2_quo[0], oside_d[DIV_STAGES-1].neg[0]);
      qy <= sat_out(d2_quo[1], oside_d[DIV_STAGES-1].neg[1]);
      qz <= sat_out(d2_quo[2], oside_d[DIV_STAGES-1].neg[2]);
      qw <= sat_out(d2_quo[3], oside_d[DIV_STAGES-1].neg[3]);
    end
    degenerate <= oside_d[DIV_STAGES-1].deg;
  end

endmodule

// ===== dv/tb_rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Checks the pipelined matrix to quaternion converter against a behavioral
// fixed-point predictor, using directed matrices and random rotations/noise.
// ---------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam int LATENCY = 161;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    logic               deg;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, degenerate;
  logic signed [IN_W-1:0] m00 = '0, m10 = '0, m20 = '0, m01 = '0, m11 = '0;
  logic signed [IN_W-1:0] m21 = '0, m02 = '0, m12 = '0, m22 = '0;
  logic signed [OUT_W-1:0] qx, qy, qz, qw;

  quat_t quat_queue[$];
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int degenerate_seen = 0;
  longint cycles = 0;

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(m00), .m10(m10), .m20(m20), .m01(m01), .m11(m11), .m21(m21),
    .m02(m02), .m12(m12), .m22(m22),
    .done(done), .qx(qx), .qy(qy), .qz(qz), .qw(qw), .degenerate(degenerate)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clip_unit(longint v);
    longint lim;
    lim = (ONE > 32767) ? 32767 : ONE;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return 16'(v);
  endfunction

  function automatic quat_t predict_quat(longint e[9]);
    // e order: m00 m10 m20 m01 m11 m21 m02 m12 m22
    longint tr, a, s, len;
    longint n[3];
    longint c[4];
    longint unsigned len2;
    axis_t axis;
    int k;
    quat_t q;
    tr = e[0] + e[4] + e[8];
    if (tr > 0) begin
      a = tr + ONE; axis = AX_W;
      n[0] = e[5] - e[7]; n[1] = e[6] - e[2]; n[2] = e[1] - e[3];
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      a = ONE + e[0] - e[4] - e[8]; axis = AX_X;
      n[0] = e[3] + e[1]; n[1] = e[6] + e[2]; n[2] = e[5] - e[7];
    end else if (e[4] > e[8]) begin
      a = ONE + e[4] - e[0] - e[8]; axis = AX_Y;
      n[0] = e[3] + e[1]; n[1] = e[7] + e[5]; n[2] = e[6] - e[2];
    end else begin
      a = ONE + e[8] - e[0] - e[4]; axis = AX_Z;
      n[0] = e[6] + e[2]; n[1] = e[7] + e[5]; n[2] = e[1] - e[3];
    end
    q = '{qx: '0, qy: '0, qz: '0, qw: '0, deg: 1'b1};
    s = 0;
    if (a > 0) s = 2 * longint'(int_sqrt(longint'(a) << FRAC_BITS));
    if (s == 0) return q;
    k = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == int'(axis)) c[i] = s / 4;
      else begin
        c[i] = (n[k] * ONE) / s;
        k++;
      end
    end
    len2 = 0;
    for (int i = 0; i < 4; i++) len2 += longint'(c[i] * c[i]);
    len = longint'(int_sqrt(len2));
    if (len == 0) return q;
    q.qx = clip_unit((c[0] * ONE) / len);
    q.qy = clip_unit((c[1] * ONE) / len);
    q.qz = clip_unit((c[2] * ONE) / len);
    q.qw = clip_unit((c[3] * ONE) / len);
    q.deg = 1'b0;
    return q;
  endfunction

  task automatic send_matrix(longint e[9]);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    m00 <= 16'(e[0]); m10 <= 16'(e[1]); m20 <= 16'(e[2]);
    m01 <= 16'(e[3]); m11 <= 16'(e[4]); m21 <= 16'(e[5]);
    m02 <= 16'(e[6]); m12 <= 16'(e[7]); m22 <= 16'(e[8]);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    quat_queue.push_back(predict_quat(e));
    requests_sent++;
    @(negedge clk);
  endtask

  // Burst mode keeps start high back to back
  task automatic send_burst(longint e[9]);
    m00 <= 16'(e[0]); m10 <= 16'(e[1]); m20 <= 16'(e[2]);
    m01 <= 16'(e[3]); m11 <= 16'(e[4]); m21 <= 16'(e[5]);
    m02 <= 16'(e[6]); m12 <= 16'(e[7]); m22 <= 16'(e[8]);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    quat_queue.push_back(predict_quat(e));
    requests_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rotation_matrix_to_quaternion test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst && done) begin
      results_seen++;
      if (quat_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result qx=%0d qy=%0d", qx, qy);
      end else begin
        exp_q = quat_queue.pop_front();
        if (exp_q.deg) degenerate_seen++;
        if (qx !== exp_q.qx || qy !== exp_q.qy || qz !== exp_q.qz ||
            qw !== exp_q.qw || degenerate !== exp_q.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d %0d deg %0b, got %0d %0d %0d %0d deg %0b",
                     exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.deg,
                     qx, qy, qz, qw, degenerate);
        end
      end
    end
  end

  function automatic void rot_matrix(output longint e[9]);
    // build a rotation from a random quaternion, in reals then truncated
    real a, b, c, d, n;
    a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(a*a + b*b + c*c + d*d);
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    a /= n; b /= n; c /= n; d /= n;   // a is w, b c d are x y z
    e[0] = longint'($rtoi((1 - 2*(c*c + d*d)) * ONE));
    e[4] = longint'($rtoi((1 - 2*(b*b + d*d)) * ONE));
    e[8] = longint'($rtoi((1 - 2*(b*b + c*c)) * ONE));
    e[1] = longint'($rtoi(2*(b*c + a*d) * ONE));
    e[3] = longint'($rtoi(2*(b*c - a*d) * ONE));
    e[2] = longint'($rtoi(2*(b*d - a*c) * ONE));
    e[6] = longint'($rtoi(2*(b*d + a*c) * ONE));
    e[5] = longint'($rtoi(2*(c*d + a*b) * ONE));
    e[7] = longint'($rtoi(2*(c*d - a*b) * ONE));
  endfunction

  task automatic test_directed();
    longint e[9];
    e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};             send_matrix(e);
    e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};           send_matrix(e);
    e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};           send_matrix(e);
    e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};           send_matrix(e);
    e = '{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE};            send_matrix(e);
    e = '{0, 0, ONE, 0, ONE, 0, -ONE, 0, 0};            send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                   send_matrix(e);
    // large negative diagonal
    e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};    send_matrix(e);
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};    send_matrix(e);
    // ties among the diagonal
    e = '{-8192, 0, 0, 0, -8192, 0, 0, 0, -8192};       send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, -1};                  send_matrix(e);
    // out-of-range extremes, all bits toggled
    e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_matrix(e);
    e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_matrix(e);
    e = '{32767, -32768, 32767, -32768, -32768, 32767, 32767, -32768, -32768};
    send_matrix(e);
    e = '{-32768, 32767, -32768, 32767, 32767, -32768, -32768, 32767, -32768};
    send_matrix(e);
    e = '{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767};
    send_matrix(e);
    // tiny trace, then a negative trace
    e = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                   send_matrix(e);
    e = '{-16383, 5, -7, 3, -16383, 9, 1, -2, 16383};   send_matrix(e);
  endtask

  task automatic test_random_rotations(int count);
    longint e[9];
    for (int i = 0; i < count; i++) begin
      rot_matrix(e);
      // perturb occasionally by a few lsbs
      if ($urandom_range(0, 3) == 0)
        for (int j = 0; j < 9; j++) e[j] += longint'($urandom_range(0, 8)) - 4;
      if ($urandom_range(0, 4) == 0) send_burst(e);
      else send_matrix(e);
    end
  endtask

  task automatic test_random_noise(int count);
    longint e[9];
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 9; j++)
        e[j] = ($urandom_range(0, 3) == 0) ? longint'($signed(16'($urandom())))
                                          : longint'($urandom_range(0, 32768)) - 16384;
      send_matrix(e);
    end
  endtask

  initial begin
    int drain;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_rotations(420);
    test_random_noise(110);
    // drop the request line after the last accepted request
    start <= 1'b0;
    drain = 0;
    while (quat_queue.size() != 0 && drain < 4 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (quat_queue.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", quat_queue.size());
    end
    $display("sent %0d matrices, checked %0d quaternions (%0d degenerate)",
             requests_sent, results_seen, degenerate_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) $display("rotation_matrix_to_quaternion test passed");
    else $display("rotation_matrix_to_quaternion test failed");
    $finish;
  end

endmodule
